FILE: hdl/bqd_pkg.sv
// Shared constants, types and register codes of the cascaded biquad low-pass unit.
`timescale 1ns / 1ps

package bqd_pkg;

    // Field widths and fixed-point format.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 14;

    // Digit-serial datapath: sample operands enter the multipliers one digit at a time.
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = SAMPLE_W / DIGIT_W;
    localparam int CNT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // Five taps per section: current input, two past inputs, two past outputs.
    localparam int N_TAPS   = 5;
    localparam int TAP_X0   = 0;
    localparam int TAP_X1   = 1;
    localparam int TAP_X2   = 2;
    localparam int TAP_Y1   = 3;
    localparam int TAP_Y2   = 4;

    // Accumulator widths: one digit product, the sum of five, the running sum.
    localparam int PROD_W   = COEF_W + DIGIT_W + 2;
    localparam int PART_W   = PROD_W + 3;
    localparam int ACC_W    = PART_W + 1;
    localparam int FULL_W   = ACC_W + SAMPLE_W;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // Coefficients carried one bit wider so the feedback taps can be negated exactly.
    typedef logic [N_TAPS-1:0][COEF_W:0]     tap_coefs_t;
    typedef logic [N_TAPS-1:0][SAMPLE_W-1:0] tap_samples_t;

    // Request from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic         start;
        tap_samples_t opnd;
    } mac_ctrl_t;

    // Report from the multiply-accumulate unit back to the sequencer.
    typedef struct packed {
        logic    done;
        sample_t res;
    } mac_stat_t;

endpackage

FILE: hdl/bqd_coefs.sv
// Coefficient registers with write decode and negated feedback taps.
`timescale 1ns / 1ps

module bqd_coefs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bqd_pkg::COEF_W-1:0]       cfg_data,
    output bqd_pkg::tap_coefs_t              coefs
);

    bqd_pkg::coef_t b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= bqd_pkg::COEF_W'(1 << bqd_pkg::FRAC_W);
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bqd_pkg::REG_B0: b0_reg <= cfg_data;
                bqd_pkg::REG_B1: b1_reg <= cfg_data;
                bqd_pkg::REG_B2: b2_reg <= cfg_data;
                bqd_pkg::REG_A1: a1_reg <= cfg_data;
                bqd_pkg::REG_A2: a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Feedback taps are subtracted, so they are handed on negated.
    always_comb
    begin
        coefs[bqd_pkg::TAP_X0] = {b0_reg[bqd_pkg::COEF_W-1], b0_reg};
        coefs[bqd_pkg::TAP_X1] = {b1_reg[bqd_pkg::COEF_W-1], b1_reg};
        coefs[bqd_pkg::TAP_X2] = {b2_reg[bqd_pkg::COEF_W-1], b2_reg};
        coefs[bqd_pkg::TAP_Y1] = -{a1_reg[bqd_pkg::COEF_W-1], a1_reg};
        coefs[bqd_pkg::TAP_Y2] = -{a2_reg[bqd_pkg::COEF_W-1], a2_reg};
    end

endmodule

FILE: hdl/bqd_mac.sv
// Digit-serial five-tap multiply-accumulate with rounding and saturation.
`timescale 1ns / 1ps

module bqd_mac
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  bqd_pkg::mac_ctrl_t      ctrl,
    input  bqd_pkg::tap_coefs_t     coefs,
    output bqd_pkg::mac_stat_t      stat
);

    localparam logic signed [bqd_pkg::FULL_W-1:0] RND =
        bqd_pkg::FULL_W'(1) <<< (bqd_pkg::FRAC_W - 1);
    localparam logic signed [bqd_pkg::FULL_W-1:0] SAT_HI =
        bqd_pkg::FULL_W'((64'sd1 <<< (bqd_pkg::SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [bqd_pkg::FULL_W-1:0] SAT_LO = -SAT_HI - 1;

    // Control state.
    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic                          done_reg;
    logic [bqd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    // Datapath: operand shift registers, running sum and the bits shifted out below it.
    bqd_pkg::tap_samples_t                opnd_reg, opnd_next;
    logic signed [bqd_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [bqd_pkg::SAMPLE_W-1:0]         low_reg, low_next;
    bqd_pkg::sample_t                     res_reg, res_next;

    logic                                 last_digit;
    logic signed [bqd_pkg::PART_W-1:0]    part;
    logic signed [bqd_pkg::ACC_W-1:0]     sum;
    logic signed [bqd_pkg::FULL_W-1:0]    full;
    logic signed [bqd_pkg::FULL_W-1:0]    shifted;

    assign last_digit = (cnt_reg == bqd_pkg::CNT_W'(bqd_pkg::DIGITS - 1));

    // One digit of every operand times its coefficient, summed over the five taps.
    // The top digit carries the sign; the lower digits are unsigned.
    always_comb
    begin
        logic signed [bqd_pkg::DIGIT_W:0]  dig;
        logic signed [bqd_pkg::PROD_W-1:0] prod;
        part = '0;
        for (int k = 0; k < bqd_pkg::N_TAPS; k++)
        begin
            if (last_digit)
                dig = {opnd_reg[k][bqd_pkg::DIGIT_W-1], opnd_reg[k][bqd_pkg::DIGIT_W-1:0]};
            else
                dig = {1'b0, opnd_reg[k][bqd_pkg::DIGIT_W-1:0]};
            prod = $signed(coefs[k]) * dig;
            part = part + bqd_pkg::PART_W'(prod);
        end
    end

    // The sum moves down one digit per step; its low digit drops into low_reg.
    assign sum = acc_reg + bqd_pkg::ACC_W'(part);

    // Rounding half up, scaling and clamping of the finished sum.
    assign full    = {acc_reg, low_reg};
    assign shifted = (full + RND) >>> bqd_pkg::FRAC_W;

    always_comb
    begin
        if (shifted > SAT_HI)
            res_next = SAT_HI[bqd_pkg::SAMPLE_W-1:0];
        else if (shifted < SAT_LO)
            res_next = SAT_LO[bqd_pkg::SAMPLE_W-1:0];
        else
            res_next = shifted[bqd_pkg::SAMPLE_W-1:0];
    end

    // Next values of the step control and the datapath.
    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        opnd_next = opnd_reg;
        acc_next  = acc_reg;
        low_next  = low_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            opnd_next = ctrl.opnd;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < bqd_pkg::N_TAPS; k++)
            begin
                opnd_next[k] = opnd_reg[k] >> bqd_pkg::DIGIT_W;
            end
            acc_next = sum >>> bqd_pkg::DIGIT_W;
            low_next = {sum[bqd_pkg::DIGIT_W-1:0],
                        low_reg[bqd_pkg::SAMPLE_W-1:bqd_pkg::DIGIT_W]};
            cnt_next = cnt_reg + 1'b1;
            if (last_digit)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= fin_reg;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
        low_reg  <= low_next;
        if (fin_reg)
            res_reg <= res_next;
    end

    assign stat.done = done_reg;
    assign stat.res  = res_reg;

endmodule

FILE: hdl/cascaded_biquad_lowpass_unit.sv
// Top level of the cascaded biquad low-pass unit: sequencer, section history, output register.
`timescale 1ns / 1ps

// Two direct-form-I biquad sections in cascade share one coefficient set and one
// digit-serial multiply-accumulate unit that takes the sample operands four bits per
// cycle. Each section runs a load step, one step per operand digit and a rounding
// step, and the cycle that hands a section's result on also loads the next step. A
// new item is taken only once the unit is idle again, after the last result has
// entered the output register. The digit count of the shared unit sets how long each
// section runs. src_stall stays high while an item is being filtered. Coefficients
// reset to a pass-through filter (b0 = 1.0); the user must write them only while the
// unit is idle, which the unit itself does not enforce.

module cascaded_biquad_lowpass_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  logic [bqd_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                            dst_valid,
    input  logic                            dst_stall,
    output logic [bqd_pkg::SAMPLE_W-1:0]    sample_out,
    input  logic                            cfg_we,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bqd_pkg::COEF_W-1:0]      cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEC1 = 4'b0010,
        ST_SEC2 = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Past inputs and outputs of each section: x1, x2, y1, y2.
    bqd_pkg::sample_t s1_x1_reg, s1_x2_reg, s1_y1_reg, s1_y2_reg;
    bqd_pkg::sample_t s2_x1_reg, s2_x2_reg, s2_y1_reg, s2_y2_reg;

    logic                dst_valid_reg, dst_valid_next;
    bqd_pkg::sample_t    sample_out_reg;

    bqd_pkg::tap_coefs_t coefs;
    bqd_pkg::mac_ctrl_t  mac_ctrl;
    bqd_pkg::mac_stat_t  mac_stat;

    logic accept;
    logic out_free;
    logic start_s1;
    logic start_s2;
    logic load_out;

    bqd_coefs u_coefs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    bqd_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coefs (coefs),
        .stat  (mac_stat)
    );

    assign src_stall = (state_reg != ST_IDLE);
    assign accept    = src_valid && !src_stall;
    assign out_free  = !dst_valid_reg || !dst_stall;

    // Section one starts on an accepted item, section two on the result of section one.
    assign start_s1 = accept;
    assign start_s2 = (state_reg == ST_SEC1) && mac_stat.done;
    assign load_out = ((state_reg == ST_SEC2) && mac_stat.done && out_free)
                   || ((state_reg == ST_OUT) && out_free);

    // Operands for the shared unit come from the section that is about to run.
    always_comb
    begin
        mac_ctrl.start = start_s1 || start_s2;
        if (state_reg == ST_SEC1)
        begin
            mac_ctrl.opnd[bqd_pkg::TAP_X0] = mac_stat.res;
            mac_ctrl.opnd[bqd_pkg::TAP_X1] = s2_x1_reg;
            mac_ctrl.opnd[bqd_pkg::TAP_X2] = s2_x2_reg;
            mac_ctrl.opnd[bqd_pkg::TAP_Y1] = s2_y1_reg;
            mac_ctrl.opnd[bqd_pkg::TAP_Y2] = s2_y2_reg;
        end
        else
        begin
            mac_ctrl.opnd[bqd_pkg::TAP_X0] = sample_in;
            mac_ctrl.opnd[bqd_pkg::TAP_X1] = s1_x1_reg;
            mac_ctrl.opnd[bqd_pkg::TAP_X2] = s1_x2_reg;
            mac_ctrl.opnd[bqd_pkg::TAP_Y1] = s1_y1_reg;
            mac_ctrl.opnd[bqd_pkg::TAP_Y2] = s1_y2_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SEC1;
            end
            ST_SEC1:
            begin
                if (mac_stat.done)
                    state_next = ST_SEC2;
            end
            ST_SEC2:
            begin
                if (mac_stat.done)
                    state_next = out_free ? ST_IDLE : ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: filled by a new result, emptied when the item is taken.
    always_comb
    begin
        dst_valid_next = dst_valid_reg;
        if (load_out)
            dst_valid_next = 1'b1;
        else if (dst_valid_reg && !dst_stall)
            dst_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dst_valid_reg <= 1'b0;
            s1_x1_reg     <= '0;
            s1_x2_reg     <= '0;
            s1_y1_reg     <= '0;
            s1_y2_reg     <= '0;
            s2_x1_reg     <= '0;
            s2_x2_reg     <= '0;
            s2_y1_reg     <= '0;
            s2_y2_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dst_valid_reg <= dst_valid_next;
            // Input history moves when a section starts, output history when it ends.
            if (start_s1)
            begin
                s1_x1_reg <= sample_in;
                s1_x2_reg <= s1_x1_reg;
            end
            if (start_s2)
            begin
                s1_y1_reg <= mac_stat.res;
                s1_y2_reg <= s1_y1_reg;
                s2_x1_reg <= mac_stat.res;
                s2_x2_reg <= s2_x1_reg;
            end
            if ((state_reg == ST_SEC2) && mac_stat.done)
            begin
                s2_y1_reg <= mac_stat.res;
                s2_y2_reg <= s2_y1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            sample_out_reg <= mac_stat.res;
    end

    assign dst_valid  = dst_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

FILE: hdl/bqd_checker.sv
// Port-level checks of the cascaded biquad low-pass unit and their binding.
`timescale 1ns / 1ps

module bqd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            src_valid,
    input logic                            src_stall,
    input logic [bqd_pkg::SAMPLE_W-1:0]    sample_in,
    input logic                            dst_valid,
    input logic                            dst_stall,
    input logic [bqd_pkg::SAMPLE_W-1:0]    sample_out
);

    // A result that is held back stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(sample_out))
    else $error("stalled result changed or was withdrawn");

    // An accepted item closes the input side; it is checked closed at two points of the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall ##10 src_stall)
    else $error("input reopened before both sections finished");

    // A new result only appears at the end of a run, while the input side was closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(src_stall))
    else $error("result appeared without an item in work");

    // An idle unit that offers no result does not raise a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid && !src_stall |=> !dst_valid)
    else $error("result appeared from an idle unit");

endmodule

bind cascaded_biquad_lowpass_unit bqd_checker u_bqd_checker (.*);
